// ----- rtl/l2q_pkg.sv -----
// Package for the Q15 base-2 logarithm pipeline.
// Holds the field widths and the interpolation table; it depends on nothing.
package l2q_pkg;

    localparam int OPERAND_W = 32;
    localparam int RESULT_W  = 21;
    localparam int EXPO_W    = 5;
    localparam int IDX_W     = 5;
    localparam int DX_W      = 15;
    localparam int FRAC_Q    = 15;
    localparam int TAB_W     = 16;
    localparam int DIFF_W    = 11;
    localparam int TAB_DEPTH = 33;
    localparam int TAB_IDX_W = 6;
    localparam int FRAC_W    = 17;
    localparam int PROD_W    = DX_W + DIFF_W;

    // Bit positions of the table index and the interpolation weight
    // in the normalized operand.
    localparam int IDX_LSB = 26;
    localparam int DX_LSB  = 11;

    // Near 32768 * log2(1 + i/32), biased slightly upward, with entry 0 held at 4.
    localparam logic [TAB_W-1:0] LOG2_TABLE [TAB_DEPTH] = '{
        16'd4,     16'd1459,  16'd2870,  16'd4240,  16'd5572,  16'd6867,
        16'd8127,  16'd9355,  16'd10552, 16'd11719, 16'd12858, 16'd13971,
        16'd15057, 16'd16120, 16'd17158, 16'd18175, 16'd19170, 16'd20145,
        16'd21100, 16'd22036, 16'd22954, 16'd23854, 16'd24738, 16'd25605,
        16'd26457, 16'd27294, 16'd28116, 16'd28924, 16'd29719, 16'd30500,
        16'd31269, 16'd32025, 16'd32769
    };

endpackage

// ----- rtl/l2q_in_if.sv -----
// Input channel of the logarithm pipeline: one operand word per handshake.
// Depends on l2q_pkg for the operand width.
interface l2q_in_if;
    import l2q_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OPERAND_W-1:0] operand;

    modport source (output valid, output operand, input ready);
    modport sink   (input valid, input operand, output ready);
endinterface

// ----- rtl/l2q_out_if.sv -----
// Output channel of the logarithm pipeline: one Q15 result word per handshake.
// Depends on l2q_pkg for the result width.
interface l2q_out_if;
    import l2q_pkg::*;

    logic                valid;
    logic                ready;
    logic [RESULT_W-1:0] log2_result;

    modport source (output valid, output log2_result, input ready);
    modport sink   (input valid, input log2_result, output ready);
endinterface

// ----- rtl/log2_q15_interpolator.sv -----
// Throughput: one word per cycle while the output is ready; each stage
// holds its word only while the stage after it is full and stalled, so
// bubbles are squeezed out. The five stages are leading-one search,
// normalizing shift, table lookup, interpolation multiply and final add.
// Reset (synchronous, active low) clears only the stage valid bits.
module log2_q15_interpolator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    l2q_in_if.sink    i_in,
    l2q_out_if.source o_out
);
    import l2q_pkg::*;

    // Stage valid bits and per-stage advance conditions.
    logic r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // Stage 1: operand and the position of its highest set bit.
    logic [OPERAND_W-1:0] r_opd1;
    logic [EXPO_W-1:0]    r_expo1;
    logic [EXPO_W-1:0]    n_expo1;

    // Stage 2: exponent, table index and interpolation weight.
    logic [EXPO_W-1:0]    r_expo2;
    logic [IDX_W-1:0]     r_idx2;
    logic [DX_W-1:0]      r_dx2;
    logic [OPERAND_W-1:0] n_norm;
    logic [EXPO_W-1:0]    n_shamt;

    // Stage 3: lower table entry and the step to the next entry.
    logic [EXPO_W-1:0]    r_expo3;
    logic [DX_W-1:0]      r_dx3;
    logic [TAB_W-1:0]     r_lo3;
    logic [DIFF_W-1:0]    r_diff3;
    logic [TAB_W-1:0]     n_lo;
    logic [TAB_W-1:0]     n_hi;
    logic [TAB_W-1:0]     n_diff;

    // Stage 4: scaled interpolation step.
    logic [EXPO_W-1:0]    r_expo4;
    logic [TAB_W-1:0]     r_lo4;
    logic [DIFF_W-1:0]    r_step4;
    logic [PROD_W-1:0]    n_prod;

    // Stage 5: the result word.
    logic [RESULT_W-1:0]  r_res5;
    logic [FRAC_W-1:0]    n_frac;

    // Each stage may load when it is empty or its word moves on.
    assign rdy5 = !r_vld5 || o_out.ready;
    assign rdy4 = !r_vld4 || rdy5;
    assign rdy3 = !r_vld3 || rdy4;
    assign rdy2 = !r_vld2 || rdy3;
    assign rdy1 = !r_vld1 || rdy2;

    assign i_in.ready        = rdy1;
    assign o_out.valid       = r_vld5;
    assign o_out.log2_result = r_res5;

    // Leading-one search; a zero operand gives exponent zero.
    always_comb begin
        n_expo1 = '0;
        for (int b = 0; b < OPERAND_W; b++) begin
            if (i_in.operand[b]) begin
                n_expo1 = EXPO_W'(b);
            end
        end
    end

    // Normalize so that the leading one sits at the top bit.
    assign n_shamt = EXPO_W'(OPERAND_W - 1) - r_expo1;
    assign n_norm  = r_opd1 << n_shamt;

    // Table lookup of the two neighboring entries.
    assign n_lo   = LOG2_TABLE[{1'b0, r_idx2}];
    assign n_hi   = LOG2_TABLE[TAB_IDX_W'(r_idx2) + TAB_IDX_W'(1)];
    assign n_diff = n_hi - n_lo;

    // Interpolation product and final sum.
    assign n_prod = PROD_W'(r_dx3) * PROD_W'(r_diff3);
    assign n_frac = FRAC_W'(r_lo4) + FRAC_W'(r_step4);

    // Valid bits travel with the words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            if (rdy1) r_vld1 <= i_in.valid;
            if (rdy2) r_vld2 <= r_vld1;
            if (rdy3) r_vld3 <= r_vld2;
            if (rdy4) r_vld4 <= r_vld3;
            if (rdy5) r_vld5 <= r_vld4;
        end
    end

    // Payload registers load together with their valid bits.
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_opd1  <= i_in.operand;
            r_expo1 <= n_expo1;
        end
        if (rdy2) begin
            r_expo2 <= r_expo1;
            r_idx2  <= n_norm[IDX_LSB +: IDX_W];
            r_dx2   <= n_norm[DX_LSB +: DX_W];
        end
        if (rdy3) begin
            r_expo3 <= r_expo2;
            r_dx3   <= r_dx2;
            r_lo3   <= n_lo;
            r_diff3 <= n_diff[DIFF_W-1:0];
        end
        if (rdy4) begin
            r_expo4 <= r_expo3;
            r_lo4   <= r_lo3;
            r_step4 <= n_prod[FRAC_Q +: DIFF_W];
        end
        if (rdy5) begin
            r_res5 <= RESULT_W'({r_expo4, {FRAC_Q{1'b0}}}) + RESULT_W'(n_frac);
        end
    end

    // The exponent in stage one marks the leading one of its operand.
    a_expo_leading_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld1 |-> ((r_opd1 >> r_expo1) == OPERAND_W'(1)) || (r_opd1 == '0))
        else $error("stage one exponent does not match the leading one");

    // Neighboring table entries never differ by more than the first step.
    a_diff_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld3 |-> r_diff3 <= DIFF_W'(1455))
        else $error("table step out of range");

    // Every result lies between 4 and 1048576.
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld5 |-> (r_res5 >= RESULT_W'(4)) && (r_res5 <= RESULT_W'(1048576)))
        else $error("result out of range");

    // An accepted operand always occupies the first stage next cycle.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld1)
        else $error("accepted operand lost at stage one");

    // A stalled output stage keeps its word.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld5 && !o_out.ready) |=> r_vld5 && $stable(r_res5))
        else $error("output word changed while stalled");

endmodule

// ----- test/tb_log2_q15_interpolator.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for log2_q15_interpolator: random and directed operand words
// are compared against a behavioral Q15 log2 model. Depends on l2q_pkg, l2q_in_if,
// l2q_out_if and the block itself.
module tb_log2_q15_interpolator;
    import l2q_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PERCENT = 12;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 80;
    localparam int CALM_FROM    = 500;
    localparam int CALM_TO      = 650;
    localparam int RANDOM_HALF  = 450;

    logic i_clk;
    logic i_rst_n;

    l2q_in_if  in_ch ();
    l2q_out_if out_ch ();

    log2_q15_interpolator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [OPERAND_W-1:0] operand_backlog [$];
    logic [RESULT_W-1:0]  log2_expected [$];
    int                   sent_words;
    int                   got_words;
    int                   mismatches;
    int                   cycles;
    int                   hold_left;
    bit                   hold_done;
    logic [RESULT_W-1:0]  want;
    wire                  calm_tx = (sent_words >= CALM_FROM) && (sent_words < CALM_TO);
    wire                  calm_rx = (got_words >= CALM_FROM) && (got_words < CALM_TO);

    // Q15 log2: leading-one exponent plus a table entry interpolated toward the next one.
    function automatic logic [RESULT_W-1:0] log2_q15_of(logic [OPERAND_W-1:0] v);
        int                   expo;
        logic [OPERAND_W-1:0] norm;
        int                   idx;
        logic [31:0]          dx;
        logic [31:0]          lo;
        logic [31:0]          hi;
        logic [31:0]          sum;
        expo = 0;
        for (int b = 0; b < OPERAND_W; b++) begin
            if (v[b]) expo = b;
        end
        norm = v << (OPERAND_W - 1 - expo);
        idx  = int'(norm[IDX_LSB +: IDX_W]);
        dx   = 32'(norm[DX_LSB +: DX_W]);
        lo   = 32'(LOG2_TABLE[idx]);
        hi   = 32'(LOG2_TABLE[idx + 1]);
        sum  = (32'(expo) << FRAC_Q) + lo + ((dx * (hi - lo)) >> FRAC_Q);
        return sum[RESULT_W-1:0];
    endfunction

    // Clock, reset and known values on every input from time zero.
    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.operand  = '0;
        out_ch.ready   = 1'b0;
        fork
            forever #5 i_clk = ~i_clk;
            begin
                repeat (12) @(posedge i_clk);
                i_rst_n <= 1'b1;
            end
        join_none
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Driver: offers backlog words, records the expected result of each accepted word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                log2_expected.push_back(log2_q15_of(in_ch.operand));
                sent_words <= sent_words + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (operand_backlog.size() != 0 &&
                    (calm_tx || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    in_ch.valid   <= 1'b1;
                    in_ch.operand <= operand_backlog.pop_front();
                end else begin
                    in_ch.valid   <= 1'b0;
                    in_ch.operand <= $urandom;
                end
            end
        end
    end

    // Monitor: checks each result word and drives ready, with one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got_words <= got_words + 1;
                if (log2_expected.size() == 0) begin
                    $error("log2_result: no word expected, actual %0d", out_ch.log2_result);
                    mismatches <= mismatches + 1;
                end else begin
                    want = log2_expected.pop_front();
                    if (out_ch.log2_result !== want) begin
                        $error("log2_result: expected %0d, actual %0d",
                               want, out_ch.log2_result);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else if (!hold_done && got_words >= HOLD_AT) begin
                hold_done    <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm_rx || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Waits until every queued word went in and every expected word came out.
    task automatic drain_pipeline();
        do @(posedge i_clk);
        while (operand_backlog.size() != 0 || in_ch.valid || log2_expected.size() != 0);
    endtask

    // Random operands, mostly with the leading one at a random position.
    task automatic queue_random(int count);
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 3);
            case (kind)
                0: operand_backlog.push_back($urandom);
                1: operand_backlog.push_back($urandom >> $urandom_range(0, 31));
                2: operand_backlog.push_back(32'h1 << $urandom_range(0, 31));
                default: operand_backlog.push_back(
                    ($urandom | 32'h8000_0000) >> $urandom_range(0, 31));
            endcase
        end
    endtask

    initial begin
        sent_words = 0;
        got_words  = 0;
        mismatches = 0;
        cycles     = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        @(posedge i_clk iff i_rst_n);

        // Zero, small values, powers of two, the largest word, both ends of table and weight, and mixed patterns.
        operand_backlog.push_back(32'h0000_0000);
        operand_backlog.push_back(32'h0000_0001);
        operand_backlog.push_back(32'h0000_0002);
        operand_backlog.push_back(32'h0000_0003);
        operand_backlog.push_back(32'h0000_0005);
        operand_backlog.push_back(32'h0001_0000);
        operand_backlog.push_back(32'h4000_0000);
        operand_backlog.push_back(32'h8000_0000);
        operand_backlog.push_back(32'hFFFF_FFFF);
        operand_backlog.push_back(32'h7FFF_FFFF);
        operand_backlog.push_back(32'hFC00_0000);
        operand_backlog.push_back(32'h8400_0000);
        operand_backlog.push_back(32'h83FF_F800);
        operand_backlog.push_back(32'h8000_07FF);
        operand_backlog.push_back(32'hFFFF_F800);
        operand_backlog.push_back(32'h0000_FFFF);
        operand_backlog.push_back(32'h5555_5555);
        operand_backlog.push_back(32'hAAAA_AAAA);
        operand_backlog.push_back(32'h0001_FFFF);
        operand_backlog.push_back(32'h0000_0800);
        drain_pipeline();

        // Two random halves with a full drain between them.
        queue_random(RANDOM_HALF);
        drain_pipeline();
        queue_random(RANDOM_HALF);
        drain_pipeline();
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && log2_expected.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
